// ===== sv/assert_macros.svh =====
// assertion macros shared by the local window entropy rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LWE_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwe assertion failed");

// next-cycle implication, disabled while reset is low
`define LWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwe assertion failed");

`endif

// ===== sv/lwe_pkg.sv =====
// shared constants, register codes and log table functions
// no dependencies; used by the interfaces, divider and top level
`timescale 1ns / 1ps

package lwe_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HALF_DEF  = 7;
    localparam int BIN_COUNT     = 256;
    localparam int MAX_ROWS      = 1024;

    localparam int PIX_W      = 8;
    localparam int ENT_W      = 16;
    localparam int COORD_W    = 10;
    localparam int ROW_W      = 10;
    localparam int HALF_W     = 3;
    localparam int VAL_W      = 8;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int DIV_DW_DEF = 25;
    localparam int DIV_NW_DEF = 8;

    localparam logic [63:0] LN2_Q28 = 64'd186065280;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_SIZE    = 3'd0,
        REG_MIN_VALUE    = 3'd1,
        REG_MAX_VALUE    = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } t_reg_idx;

    // natural log in q32 by repeated squaring, evaluated at elaboration only
    function automatic logic [63:0] f_ln_q32(input int unsigned c);
        int unsigned k;
        int          i;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] l2;
        k    = 0;
        frac = 64'd0;
        if (c == 0) begin
            return 64'd0;
        end
        for (i = 0; i < 31; i++) begin
            if ((c >> (k + 1)) != 0) begin
                k++;
            end
        end
        x = 64'(c) << (30 - k);
        for (i = 0; i < 32; i++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x    = x >> 1;
                frac = frac | 64'd1;
            end
        end
        l2 = (64'(k) << 32) | frac;
        return (l2 * LN2_Q28 + (64'd1 << 27)) >> 28;
    endfunction

    // c*ln(c) in q13
    function automatic logic [63:0] f_xlogx(input int unsigned c);
        if (c == 0) begin
            return 64'd0;
        end
        return (64'(c) * f_ln_q32(c) + (64'd1 << 18)) >> 19;
    endfunction

    // ln(n) in q13
    function automatic logic [63:0] f_ln_q13(input int unsigned n);
        return (f_ln_q32(n) + (64'd1 << 18)) >> 19;
    endfunction

endpackage

// ===== sv/lwe_pix_if.sv =====
// pixel request channel: valid, ready and one grey value
// depends on lwe_pkg
`timescale 1ns / 1ps

interface lwe_pix_if;
    import lwe_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/lwe_res_if.sv =====
// result request channel: entropy value, window corner and frame end flag
// depends on lwe_pkg
`timescale 1ns / 1ps

interface lwe_res_if;
    import lwe_pkg::*;

    logic               valid;
    logic               ready;
    logic [ENT_W-1:0]   entropy_value;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               last_of_frame;

    modport source (output valid, output entropy_value, output out_col, output out_row,
                    output last_of_frame, input ready);
    modport sink   (input valid, input entropy_value, input out_col, input out_row,
                    input last_of_frame, output ready);
endinterface

// ===== sv/local_window_entropy.sv =====
// local window entropy: line store and 256-bin histogram ram, slid per pixel
// a pixel that closes no window is written to the line store and the block stays idle; a window
// pixel is accepted, then 2*(2h+1) histogram read-modify-writes run ((2h+1)^2 at the first window
// of a row), then the histogram pipeline drains, the divider runs and the result register loads;
// pixels are taken one at a time, the next accept waits for that and for a free result
// register. synchronous active-low reset clears control, config and valid bits
`timescale 1ns / 1ps
`include "assert_macros.svh"

module local_window_entropy #(
    parameter int MAX_WIDTH = lwe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HALF  = lwe_pkg::MAX_HALF_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lwe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lwe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lwe_pix_if.sink                         i_pix,
    lwe_res_if.source                       o_res
);
    import lwe_pkg::*;

    localparam int SIDE_MAX = 2 * MAX_HALF + 1;
    localparam int AREA_MAX = SIDE_MAX * SIDE_MAX;
    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int SW       = $clog2(SIDE_MAX);
    localparam int HW       = $clog2(MAX_HALF + 1);
    localparam int H2W      = HW + 1;
    localparam int CW       = $clog2(AREA_MAX + 1);
    localparam int AW       = $clog2(SIDE_MAX * MAX_WIDTH);
    localparam int BW       = $clog2(BIN_COUNT);
    localparam int TW       = $clog2(f_xlogx(AREA_MAX) + 1);
    localparam int SUM_W    = TW;
    localparam int DW       = SUM_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // constant tables
    logic [TW-1:0]    w_xtab [AREA_MAX+1];
    logic [ENT_W-1:0] w_lnn  [MAX_HALF+1];

    for (genvar g = 0; g <= AREA_MAX; g++) begin : g_xtab
        assign w_xtab[g] = TW'(f_xlogx(g));
    end
    for (genvar g = 0; g <= MAX_HALF; g++) begin : g_lnn
        assign w_lnn[g] = ENT_W'(f_ln_q13((2 * g + 1) * (2 * g + 1)));
    end

    // configuration
    logic [HALF_W-1:0] r_half;
    logic [VAL_W-1:0]  r_min;
    logic [VAL_W-1:0]  r_max;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              w_cfg_hit;

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == REG_HALF_SIZE
                                 || i_cfg_index == REG_MIN_VALUE
                                 || i_cfg_index == REG_MAX_VALUE
                                 || i_cfg_index == REG_IMAGE_WIDTH
                                 || i_cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= HALF_W'(1);
            r_min    <= '0;
            r_max    <= '1;
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_HALF_SIZE) begin
                r_half <= i_cfg_data[HALF_W-1:0];
            end
            if (i_cfg_index == REG_MIN_VALUE) begin
                r_min <= i_cfg_data[VAL_W-1:0];
            end
            if (i_cfg_index == REG_MAX_VALUE) begin
                r_max <= i_cfg_data[VAL_W-1:0];
            end
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[DIM_W-1:0];
            end
            if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data[DIM_W-1:0];
            end
        end
    end

    // effective geometry
    logic [HW-1:0]    w_h;
    logic [H2W-1:0]   w_2h;
    logic [H2W-1:0]   w_side;
    logic [XW:0]      w_wid;
    logic [DIM_W-1:0] w_hgt;

    assign w_h    = (int'(r_half) > MAX_HALF) ? HW'(MAX_HALF) : HW'(r_half);
    assign w_2h   = {w_h, 1'b0};
    assign w_side = w_2h + 1'b1;
    assign w_wid  = (r_width == '0) ? (XW+1)'(1)
                  : (int'(r_width) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(r_width);
    assign w_hgt  = (r_height == '0) ? DIM_W'(1)
                  : (int'(r_height) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : r_height;

    // control state
    t_state          r_state;
    logic [XW-1:0]   r_x;
    logic [ROW_W-1:0] r_y;
    logic [SW-1:0]   r_wslot;
    logic [XW-1:0]   r_xl;
    logic [XW-1:0]   r_left;
    logic [ROW_W-1:0] r_top;
    logic            r_last;
    logic            r_init;
    logic [CW-1:0]   r_n;
    logic [XW-1:0]   r_col;
    logic            r_add;
    logic [SW-1:0]   r_slot;
    logic [SW-1:0]   r_topslot;
    logic [SW-1:0]   r_rcnt;
    logic [SW-1:0]   r_ccnt;

    logic w_in_acc;
    logic w_win;
    logic w_row_start;
    logic w_last;
    logic w_x_wrap;
    logic w_y_wrap;
    logic [SW-1:0] w_slot_nx;
    logic [SW-1:0] w_wslot_nx;
    logic w_pipe_busy;
    logic w_div_start;
    logic w_div_done;
    logic w_out_load;
    logic w_col_end;
    logic w_run_end;

    // histogram pipeline
    logic             r_s1_vld;
    logic             r_s1_add;
    logic             r_s2_vld;
    logic             r_s2_add;
    logic [BW-1:0]    r_s2_bin;
    logic             r_s3_vld;
    logic             r_s3_add;
    logic [CW-1:0]    r_s3_hi;
    logic [CW-1:0]    r_s3_lo;
    logic             r_s4_vld;
    logic             r_s4_add;
    logic [TW-1:0]    r_s4_delta;
    logic [SUM_W-1:0] r_sum;
    logic             r_wr_vld;
    logic [BW-1:0]    r_wr_bin;
    logic [CW-1:0]    r_wr_cnt;
    logic [BIN_COUNT-1:0] r_bvld;

    logic [AW-1:0]    w_rs_waddr;
    logic [AW-1:0]    w_rs_raddr;
    logic [PIX_W-1:0] w_rs_q;
    logic [CW-1:0]    w_h_q;
    logic [CW-1:0]    w_craw;
    logic [CW-1:0]    w_cnew;
    logic             w_ok;
    logic             w_counted;
    logic             w_h_we;
    logic [DW-1:0]    w_quo;
    logic [ENT_W-1:0] w_ent;

    assign w_in_acc    = i_pix.valid && i_pix.ready;
    assign w_win       = (32'(r_x) >= 32'(w_2h)) && (32'(r_y) >= 32'(w_2h));
    assign w_row_start = 32'(r_x) == 32'(w_2h);
    assign w_last      = (32'(r_x) == 32'(w_wid) - 1) && (32'(r_y) == 32'(w_hgt) - 1);
    assign w_x_wrap    = 32'(r_x) + 1 >= 32'(w_wid);
    assign w_y_wrap    = 32'(r_y) + 1 >= 32'(w_hgt);
    assign w_wslot_nx  = (32'(r_wslot) + 1 == 32'(w_side)) ? '0 : r_wslot + 1'b1;
    assign w_slot_nx   = (32'(r_slot) + 1 == 32'(w_side)) ? '0 : r_slot + 1'b1;
    assign w_pipe_busy = r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;
    assign w_div_start = (r_state == S_DRAIN) && !w_pipe_busy;
    assign w_out_load  = (r_state == S_DONE) && (!o_res.valid || o_res.ready);
    assign w_col_end   = 32'(r_rcnt) == 32'(w_side) - 1;
    assign w_run_end   = w_col_end && (32'(r_ccnt) == (r_init ? 32'(w_2h) : 32'd1));

    assign i_pix.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_wslot <= '0;
        end else if (w_cfg_hit) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_wslot <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_x_wrap) begin
                            r_x <= '0;
                            if (w_y_wrap) begin
                                r_y     <= '0;
                                r_wslot <= '0;
                            end else begin
                                r_y     <= r_y + 1'b1;
                                r_wslot <= w_wslot_nx;
                            end
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                        if (w_win) begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_run_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!w_pipe_busy) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window walk: rows of one column, then the next column
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc && w_win) begin
            r_xl      <= r_x;
            r_left    <= r_x - XW'(w_2h);
            r_top     <= r_y - ROW_W'(w_2h);
            r_last    <= w_last;
            r_init    <= w_row_start;
            r_n       <= CW'(w_side) * CW'(w_side);
            r_topslot <= w_wslot_nx;
            r_slot    <= w_wslot_nx;
            r_rcnt    <= '0;
            r_ccnt    <= '0;
            r_col     <= w_row_start ? '0 : r_x - XW'(w_2h) - 1'b1;
            r_add     <= w_row_start;
        end else if (r_state == S_RUN) begin
            if (w_col_end) begin
                r_rcnt <= '0;
                r_slot <= r_topslot;
                r_ccnt <= r_ccnt + 1'b1;
                r_col  <= r_init ? r_col + 1'b1 : r_xl;
                r_add  <= 1'b1;
            end else begin
                r_rcnt <= r_rcnt + 1'b1;
                r_slot <= w_slot_nx;
            end
        end
    end

    assign w_rs_waddr = AW'(r_wslot) * AW'(MAX_WIDTH) + AW'(r_x);
    assign w_rs_raddr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_col);

    lwe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SIDE_MAX * MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (w_rs_waddr),
        .i_wdata (i_pix.pixel),
        .i_raddr (w_rs_raddr),
        .o_rdata (w_rs_q)
    );

    // bin count read-modify-write, forwarding the write of the previous cycle
    assign w_craw = (r_wr_vld && r_wr_bin == r_s2_bin) ? r_wr_cnt
                  : (r_bvld[r_s2_bin] ? w_h_q : '0);
    assign w_ok      = r_s2_add ? (32'(w_craw) < AREA_MAX) : (w_craw != '0);
    assign w_cnew    = r_s2_add ? w_craw + 1'b1 : w_craw - 1'b1;
    assign w_counted = (r_s2_bin >= r_min) && (r_s2_bin <= r_max);
    assign w_h_we    = r_s2_vld && w_ok;

    lwe_ram #(
        .WIDTH (CW),
        .DEPTH (BIN_COUNT)
    ) u_bin_counts (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (r_s2_bin),
        .i_wdata (w_cnew),
        .i_raddr (w_rs_q),
        .o_rdata (w_h_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_bvld   <= '0;
            r_sum    <= '0;
        end else begin
            r_s1_vld <= (r_state == S_RUN);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && w_ok && w_counted;
            r_s4_vld <= r_s3_vld;
            if (w_cfg_hit || (r_state == S_IDLE && w_in_acc && w_win && w_row_start)) begin
                r_wr_vld <= 1'b0;
                r_bvld   <= '0;
                r_sum    <= '0;
            end else begin
                r_wr_vld <= w_h_we;
                if (w_h_we) begin
                    r_bvld[r_s2_bin] <= 1'b1;
                end
                if (r_s4_vld) begin
                    r_sum <= r_s4_add ? r_sum + SUM_W'(r_s4_delta)
                                      : r_sum - SUM_W'(r_s4_delta);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_add   <= r_add;
        r_s2_add   <= r_s1_add;
        r_s2_bin   <= w_rs_q;
        r_wr_bin   <= r_s2_bin;
        r_wr_cnt   <= w_cnew;
        r_s3_add   <= r_s2_add;
        r_s3_hi    <= r_s2_add ? w_cnew : w_craw;
        r_s3_lo    <= r_s2_add ? w_craw : w_cnew;
        r_s4_add   <= r_s3_add;
        r_s4_delta <= w_xtab[r_s3_hi] - w_xtab[r_s3_lo];
    end

    // rounded mean of the c*ln(c) sum
    lwe_div #(
        .DW (DW),
        .NW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({1'b0, r_sum} + DW'(r_n >> 1)),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_ent = (32'(w_quo) >= 32'(w_lnn[w_h])) ? '0 : w_lnn[w_h] - ENT_W'(w_quo);

    // output register
    logic               r_out_vld;
    logic [ENT_W-1:0]   r_out_ent;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ent  <= w_ent;
            r_out_col  <= COORD_W'(r_left);
            r_out_row  <= COORD_W'(r_top);
            r_out_last <= r_last;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.entropy_value = r_out_ent;
    assign o_res.out_col       = r_out_col;
    assign o_res.out_row       = r_out_row;
    assign o_res.last_of_frame = r_out_last;

    `LWE_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n, r_state == S_IDLE, !w_pipe_busy)
    `LWE_ASSERT(a_dec_finds_count, i_clk, i_rst_n, r_s2_vld && !r_s2_add, w_craw != '0)
    `LWE_ASSERT(a_inc_below_area, i_clk, i_rst_n, r_s2_vld && r_s2_add, 32'(w_craw) < AREA_MAX)
    `LWE_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, w_cfg_hit, r_x == '0 && r_y == '0)

endmodule

// ===== sv/lwe_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module lwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lwe_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on lwe_pkg for default widths and on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lwe_div #(
    parameter int DW = lwe_pkg::DIV_DW_DEF,
    parameter int NW = lwe_pkg::DIV_NW_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    import lwe_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [NW-1:0]    r_div;
    logic [NW:0]      w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? NW'(w_trial - {1'b0, r_div}) : w_trial[NW-1:0];
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `LWE_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy))

endmodule

// ===== verif/lwe_entropy_checker.sv =====
// watches the pixel, result and register ports of local_window_entropy and predicts each result
// depends on lwe_pkg, lwe_pix_if and lwe_res_if
`timescale 1ns / 1ps

module lwe_entropy_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lwe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lwe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lwe_pix_if                             pix,
    lwe_res_if                             res,
    output int                             o_fail_count,
    output int                             o_pending
);
    import lwe_pkg::*;

    localparam int SIDE_LIM = 2 * MAX_HALF_DEF + 1;
    localparam int AREA_LIM = SIDE_LIM * SIDE_LIM;

    typedef struct packed {
        logic [ENT_W-1:0]   ent;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_win_result;

    t_win_result       window_q[$];
    logic [PIX_W-1:0]  line_mem [0:SIDE_LIM*MAX_WIDTH_DEF-1];
    int unsigned       hist [BIN_COUNT];
    int unsigned       clogc_tab [0:AREA_LIM];
    int unsigned       clogc_sum;
    int unsigned       cur_col, cur_row;
    logic [HALF_W-1:0] half_reg;
    logic [VAL_W-1:0]  lo_reg, hi_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;

    // log2 by repeated squaring, scaled to natural log, all in q32
    function automatic logic [63:0] nat_log_q32(input int unsigned c);
        int unsigned msb;
        int          i;
        logic [63:0] sq;
        logic [63:0] bits;
        logic [63:0] lg2;
        msb  = 0;
        bits = 64'd0;
        if (c == 0) begin
            return 64'd0;
        end
        while (msb < 31 && (c >> (msb + 1)) != 0) begin
            msb++;
        end
        sq = 64'(c) << (30 - msb);
        for (i = 0; i < 32; i++) begin
            sq   = (sq * sq) >> 30;
            bits = bits << 1;
            if (sq >= (64'd1 << 31)) begin
                sq   = sq >> 1;
                bits = bits | 64'd1;
            end
        end
        lg2 = (64'(msb) << 32) | bits;
        return (lg2 * 64'd186065280 + (64'd1 << 27)) >> 28;
    endfunction

    initial begin
        clogc_tab[0] = 0;
        for (int c = 1; c <= AREA_LIM; c++) begin
            clogc_tab[c] = int'((64'(c) * nat_log_q32(c) + (64'd1 << 18)) >> 19);
        end
    end

    function automatic bit in_band(input logic [PIX_W-1:0] v);
        return v >= lo_reg && v <= hi_reg;
    endfunction

    function automatic void new_frame();
        cur_col   = 0;
        cur_row   = 0;
        clogc_sum = 0;
        foreach (hist[b]) hist[b] = 0;
    endfunction

    function automatic void bin_add(input logic [PIX_W-1:0] v);
        int unsigned c;
        c = hist[v];
        if (c < AREA_LIM) begin
            hist[v] = c + 1;
            if (in_band(v)) clogc_sum += clogc_tab[c+1] - clogc_tab[c];
        end
    endfunction

    function automatic void bin_drop(input logic [PIX_W-1:0] v);
        int unsigned c;
        c = hist[v];
        if (c != 0) begin
            hist[v] = c - 1;
            if (in_band(v)) clogc_sum -= clogc_tab[c] - clogc_tab[c-1];
        end
    endfunction

    function automatic void sweep_column(input int unsigned col, input int unsigned top,
                                         input int unsigned side, input bit add);
        logic [PIX_W-1:0] v;
        for (int unsigned r = top; r < top + side; r++) begin
            v = line_mem[(r % side) * MAX_WIDTH_DEF + col];
            if (add) bin_add(v);
            else bin_drop(v);
        end
    endfunction

    function automatic void predict_window(input logic [PIX_W-1:0] v);
        int unsigned hh, side, w, ht, x, y, n, lnn, q;
        longint      e;
        t_win_result r;
        hh   = (half_reg > MAX_HALF_DEF) ? MAX_HALF_DEF : half_reg;
        side = 2 * hh + 1;
        w    = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
        ht   = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);
        x    = (cur_col >= w) ? w - 1 : cur_col;
        y    = (cur_row >= ht) ? ht - 1 : cur_row;
        line_mem[(y % side) * MAX_WIDTH_DEF + x] = v;
        if (x >= 2 * hh && y >= 2 * hh) begin
            n   = side * side;
            lnn = int'((nat_log_q32(n) + (64'd1 << 18)) >> 19);
            if (x == 2 * hh) begin
                clogc_sum = 0;
                foreach (hist[b]) hist[b] = 0;
                for (int unsigned c = 0; c < side; c++) sweep_column(c, y - 2 * hh, side, 1'b1);
            end else begin
                sweep_column(x - 2 * hh - 1, y - 2 * hh, side, 1'b0);
                sweep_column(x, y - 2 * hh, side, 1'b1);
            end
            q = int'((64'(clogc_sum) + n / 2) / n);
            e = longint'(lnn) - longint'(q);
            if (e < 0) e = 0;
            if (e > 65535) e = 65535;
            r.ent  = e[ENT_W-1:0];
            r.col  = COORD_W'(x - 2 * hh);
            r.row  = COORD_W'(y - 2 * hh);
            r.last = (x == w - 1 && y == ht - 1);
            window_q.push_back(r);
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= ht) y = 0;
        end
        cur_col = x;
        cur_row = y;
    endfunction

    always @(posedge i_clk) begin
        t_win_result want, got;
        if (!i_rst_n) begin
            half_reg     = 1;
            lo_reg       = 0;
            hi_reg       = 255;
            width_reg    = 1024;
            height_reg   = 1024;
            o_fail_count = 0;
            new_frame();
            window_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HALF_SIZE:    begin half_reg = i_cfg_data[HALF_W-1:0]; new_frame(); end
                    REG_MIN_VALUE:    begin lo_reg = i_cfg_data[VAL_W-1:0]; new_frame(); end
                    REG_MAX_VALUE:    begin hi_reg = i_cfg_data[VAL_W-1:0]; new_frame(); end
                    REG_IMAGE_WIDTH:  begin width_reg = i_cfg_data; new_frame(); end
                    REG_IMAGE_HEIGHT: begin height_reg = i_cfg_data; new_frame(); end
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                got = '{res.entropy_value, res.out_col, res.out_row, res.last_of_frame};
                if (window_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result ent=%0d col=%0d row=%0d last=%0d",
                                 got.ent, got.col, got.row, got.last);
                end else begin
                    want = window_q.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch exp ent=%0d col=%0d row=%0d last=%0d,",
                                     want.ent, want.col, want.row, want.last,
                                     " got ent=%0d col=%0d row=%0d last=%0d",
                                     got.ent, got.col, got.row, got.last);
                    end
                end
            end
            if (pix.valid && pix.ready) predict_window(pix.pixel);
        end
        o_pending = window_q.size();
    end
endmodule

// ===== verif/tb_local_window_entropy.sv =====
// top of the local_window_entropy bench: clock, reset, register writes and pixel/result traffic
// depends on lwe_pkg, the channel interfaces, lwe_entropy_checker and the block itself
`timescale 1ns / 1ps

module tb_local_window_entropy;
    import lwe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd5;
    localparam int SETTLE_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count;
    int                    pending;
    bit                    quiet = 1'b0;
    bit                    src_gaps = 1'b1;
    int                    sink_burst = 0;
    int                    rand_items = 0;
    int                    pix_mode = 0;
    int                    pix_base = 0;

    lwe_pix_if pix_ch ();
    lwe_res_if res_ch ();

    always #5 i_clk = ~i_clk;

    local_window_entropy dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_ch),
        .o_res       (res_ch)
    );

    lwe_entropy_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .pix          (pix_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side back-pressure in bursts, with calm stretches
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            res_ch.ready <= 1'b1;
        end else if (sink_burst > 0) begin
            sink_burst   <= sink_burst - 1;
            res_ch.ready <= 1'b0;
        end else if (($urandom_range(0, 1023) < 512) && $urandom_range(0, 7) == 0) begin
            sink_burst   <= $urandom_range(0, 13);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic drain_idle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all five registers back to back, optionally followed by an unused index
    task automatic set_frame(input int hs, input int lo, input int hi, input int w, input int ht,
                             input bit poke_unused);
        drain_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_HALF_SIZE;
        i_cfg_data  <= CFG_DATA_W'(hs);
        @(posedge i_clk);
        i_cfg_index <= REG_MIN_VALUE;
        i_cfg_data  <= CFG_DATA_W'(lo);
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_VALUE;
        i_cfg_data  <= CFG_DATA_W'(hi);
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(ht);
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_index <= UNUSED_REG_IDX;
            i_cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        if (src_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= v;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case (pix_mode)
            0: return PIX_W'($urandom);
            1: return PIX_W'(pix_base + $urandom_range(0, 3));
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    initial begin
        int hs, w, ht, lo, hi, npix;
        int phase_no;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        phase_no = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-pixel window on a degenerate 1x1 image, both zero sizes
        set_frame(0, 0, 255, 0, 0, 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        // empty band: every result is ln(n)
        set_frame(1, 10, 5, 3, 3, 1'b1);
        for (int i = 0; i < 9; i++) send_pixel(PIX_W'($urandom));
        // image narrower than the window: no results
        set_frame(1, 0, 255, 2, 5, 1'b0);
        for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom));
        // single-value band with values inside it and at both ends of the pixel range, outside it
        set_frame(1, 100, 100, 4, 3, 1'b0);
        for (int i = 0; i < 12; i++)
            send_pixel(i % 3 == 0 ? 8'd0 : (i % 3 == 1 ? 8'd100 : 8'd255));

        // saturated width and height, start of the first row and column
        set_frame(0, 0, 255, 2047, 1, 1'b0);
        for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom));
        set_frame(0, 0, 255, 1, 2047, 1'b0);
        for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom));

        while (rand_items < 1140) begin
            hs = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 3);
            w  = 2 * hs + 1 + $urandom_range(0, 10) - ($urandom_range(0, 7) == 0 ? 2 : 0);
            ht = 2 * hs + 1 + $urandom_range(0, 6) - ($urandom_range(0, 7) == 0 ? 2 : 0);
            if (w < 1) w = 1;
            if (ht < 1) ht = 1;
            if (hs == 7) begin
                w  = 15 + $urandom_range(0, 2);
                ht = 15;
            end
            case ($urandom_range(0, 3))
                0: begin lo = 0; hi = 255; end
                1: begin lo = $urandom_range(0, 255); hi = $urandom_range(lo, 255); end
                2: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); end
                default: begin lo = $urandom_range(0, 128); hi = 255; end
            endcase
            set_frame(hs, lo, hi, w, ht, $urandom_range(0, 3) == 0);
            pix_mode = $urandom_range(0, 2);
            pix_base = $urandom_range(0, 252);
            src_gaps = $urandom_range(0, 3) != 0;
            quiet    = rand_items > 950;
            npix     = w * ht * $urandom_range(1, 2) + ($urandom_range(0, 3) == 0 ? w + 1 : 0);
            for (int i = 0; i < npix; i++) begin
                // once, hold the pixels back until every result is out
                if (phase_no == 1 && i == npix / 2) begin
                    pix_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_pixel(pick_pixel());
            end
            rand_items += npix;
            phase_no++;
        end

        quiet = 1'b1;
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lwe_pkg.sv
sv/lwe_pix_if.sv
sv/lwe_res_if.sv
sv/lwe_ram.sv
sv/lwe_div.sv
sv/local_window_entropy.sv
verif/lwe_entropy_checker.sv
verif/tb_local_window_entropy.sv
